/* rtl/core/apq_pkg.sv */
// apq_pkg: shared types and constants for the addressable priority queue.
// Used by apq_table, apq_cmp and addressable_priority_queue; no dependencies.
package apq_pkg;

    localparam int ID_BITS     = 6;
    localparam int NUM_SLOTS   = 2 ** ID_BITS;
    localparam int WEIGHT_BITS = 16;
    localparam int ARR_BITS    = 32;
    localparam int CNT_BITS    = ID_BITS + 1;

    localparam logic [WEIGHT_BITS-1:0] WEIGHT_MAX = {WEIGHT_BITS{1'b1}};

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_RAISE  = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_QUERY  = 2'd3;

    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_OCCUPIED = 2'd1;
    localparam logic [1:0] STAT_EMPTY    = 2'd2;

    typedef struct packed {
        logic [1:0]             req_type;
        logic [ID_BITS-1:0]     entry_id;
        logic [WEIGHT_BITS-1:0] weight_value;
    } t_req;

    typedef struct packed {
        logic [1:0]             status;
        logic                   top_valid;
        logic [ID_BITS-1:0]     top_id;
        logic [WEIGHT_BITS-1:0] top_weight;
    } t_rsp;

    typedef struct packed {
        logic [ARR_BITS-1:0]    arrival;
        logic [WEIGHT_BITS-1:0] weight;
    } t_slot;

    typedef struct packed {
        logic               en;        // update valid bit
        logic               valid;     // new valid bit value
        logic               data_en;   // write weight/arrival word
        logic [ID_BITS-1:0] addr;
        t_slot              slot;
    } t_tbl_wr;

endpackage

/* rtl/core/addressable_priority_queue.sv */
// Addressable priority queue: insert / raise / remove / query over 64 slots.
// Each request passes lookup, update, a scan over all slots through one comparator
// at one memory read per cycle, and output load. A request is taken only in idle, so
// not before the last result is loaded; it is taken while that result waits in the
// output register. Sync active-low reset clears valid bits, the arrival counter and
// the sequencer; slot data is undefined until written.
module addressable_priority_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  apq_pkg::t_req i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output apq_pkg::t_rsp o_out_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_APPLY,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                             r_state;
    apq_pkg::t_req                      r_req;
    logic [1:0]                         r_status;
    logic [apq_pkg::ARR_BITS-1:0]       r_arrival_cnt;
    logic [apq_pkg::CNT_BITS-1:0]       r_cnt;
    logic                               r_found;
    logic [apq_pkg::ID_BITS-1:0]        r_best_id;
    apq_pkg::t_slot                     r_best;
    logic                               r_out_valid;
    apq_pkg::t_rsp                      r_out_data;

    apq_pkg::t_tbl_wr                   tbl_wr;
    logic [apq_pkg::ID_BITS-1:0]        rd_addr;
    logic                               rd_valid;
    apq_pkg::t_slot                     rd_slot;
    logic                               take;
    logic [apq_pkg::WEIGHT_BITS:0]      raise_sum;
    logic [apq_pkg::WEIGHT_BITS-1:0]    raise_w;
    logic [1:0]                         apply_status;
    logic                               cand_valid;
    logic [apq_pkg::ID_BITS-1:0]        cand_id;

    apq_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (tbl_wr),
        .i_rd_addr  (rd_addr),
        .o_rd_valid (rd_valid),
        .o_rd_slot  (rd_slot)
    );

    apq_cmp u_cmp (
        .i_cand_valid (cand_valid),
        .i_cand       (rd_slot),
        .i_best_found (r_found),
        .i_best       (r_best),
        .o_take       (take)
    );

    assign raise_sum = {1'b0, rd_slot.weight} + {1'b0, r_req.weight_value};
    assign raise_w   = raise_sum[apq_pkg::WEIGHT_BITS] ? apq_pkg::WEIGHT_MAX
                                                       : raise_sum[apq_pkg::WEIGHT_BITS-1:0];

    // scan step k reads slot k and compares slot k-1
    assign cand_valid = (r_state == S_SCAN) && (r_cnt != '0) && rd_valid;
    assign cand_id    = r_cnt[apq_pkg::ID_BITS-1:0] - apq_pkg::ID_BITS'(1);

    always_comb begin
        tbl_wr       = '0;
        tbl_wr.addr  = r_req.entry_id;
        apply_status = apq_pkg::STAT_OK;
        rd_addr      = r_cnt[apq_pkg::ID_BITS-1:0];
        if (r_state == S_IDLE) begin
            rd_addr = i_in_data.entry_id;
        end
        if (r_state == S_APPLY) begin
            unique case (r_req.req_type)
                apq_pkg::REQ_INSERT: begin
                    if (rd_valid) begin
                        apply_status = apq_pkg::STAT_OCCUPIED;
                    end else begin
                        tbl_wr.en           = 1'b1;
                        tbl_wr.valid        = 1'b1;
                        tbl_wr.data_en      = 1'b1;
                        tbl_wr.slot.arrival = r_arrival_cnt;
                        tbl_wr.slot.weight  = r_req.weight_value;
                    end
                end
                apq_pkg::REQ_RAISE: begin
                    if (!rd_valid) begin
                        apply_status = apq_pkg::STAT_EMPTY;
                    end else begin
                        tbl_wr.data_en      = 1'b1;
                        tbl_wr.slot.arrival = rd_slot.arrival;
                        tbl_wr.slot.weight  = raise_w;
                    end
                end
                apq_pkg::REQ_REMOVE: begin
                    if (!rd_valid) begin
                        apply_status = apq_pkg::STAT_EMPTY;
                    end else begin
                        tbl_wr.en    = 1'b1;
                        tbl_wr.valid = 1'b0;
                    end
                end
                default: apply_status = apq_pkg::STAT_OK;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_arrival_cnt <= '0;
            r_cnt         <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_req   <= i_in_data;
                        r_state <= S_APPLY;
                    end
                end
                S_APPLY: begin
                    r_status <= apply_status;
                    if ((r_req.req_type == apq_pkg::REQ_INSERT) && tbl_wr.en) begin
                        r_arrival_cnt <= r_arrival_cnt + apq_pkg::ARR_BITS'(1);
                    end
                    r_cnt   <= '0;
                    r_found <= 1'b0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (take) begin
                        r_found   <= 1'b1;
                        r_best_id <= cand_id;
                        r_best    <= rd_slot;
                    end
                    r_cnt <= r_cnt + apq_pkg::CNT_BITS'(1);
                    if (r_cnt == apq_pkg::CNT_BITS'(apq_pkg::NUM_SLOTS)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid           <= 1'b1;
                        r_out_data.status     <= r_status;
                        r_out_data.top_valid  <= r_found;
                        r_out_data.top_id     <= r_found ? r_best_id : '0;
                        r_out_data.top_weight <= r_found ? r_best.weight : '0;
                        r_state               <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

/* rtl/core/apq_table.sv */
// apq_table: slot storage; valid bits in flops, weight/arrival in a 1W1R memory.
// Read data is registered. Depends on apq_pkg.
module apq_table (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  apq_pkg::t_tbl_wr            i_wr,
    input  logic [apq_pkg::ID_BITS-1:0] i_rd_addr,
    output logic                        o_rd_valid,
    output apq_pkg::t_slot              o_rd_slot
);

    apq_pkg::t_slot                  mem [apq_pkg::NUM_SLOTS];
    logic [apq_pkg::NUM_SLOTS-1:0]   r_valid;
    logic                            r_rd_valid;
    apq_pkg::t_slot                  r_rd_slot;

    always_ff @(posedge i_clk) begin
        if (i_wr.data_en) begin
            mem[i_wr.addr] <= i_wr.slot;
        end
        r_rd_slot <= mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= i_wr.valid;
            end
            r_rd_valid <= r_valid[i_rd_addr];
        end
    end

    assign o_rd_valid = r_rd_valid;
    assign o_rd_slot  = r_rd_slot;

endmodule

/* rtl/core/apq_cmp.sv */
// apq_cmp: priority comparator shared by every step of the top-entry scan.
// Higher weight wins, then the older arrival stamp. Depends on apq_pkg.
module apq_cmp (
    input  logic           i_cand_valid,
    input  apq_pkg::t_slot i_cand,
    input  logic           i_best_found,
    input  apq_pkg::t_slot i_best,
    output logic           o_take
);

    logic w_gt;
    logic w_eq;
    logic a_lt;

    assign w_gt = i_cand.weight > i_best.weight;
    assign w_eq = i_cand.weight == i_best.weight;
    assign a_lt = i_cand.arrival < i_best.arrival;

    // strict compares keep the lower slot on a full tie
    assign o_take = i_cand_valid && (!i_best_found || w_gt || (w_eq && a_lt));

endmodule

/* dv/tb_top.sv */
// tb_top: self-checking testbench for addressable_priority_queue.
// Drives insert/raise/remove/query beats and checks every result against an
// in-bench table model. Depends on apq_pkg and the RTL top only.
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_CYCLES  = 600_000;
    localparam int RANDOM_REQS = 1300;
    localparam int HOLD_AT     = 400;   // request count that starts the long output stall
    localparam int HOLD_LEN    = 800;
    localparam int TAIL_CYCLES = 100;

    typedef struct {
        apq_pkg::t_req req;
        int unsigned   gap;
        bit            wait_drain;   // hold this beat until every result is back
    } t_queued_req;

    logic          i_clk;
    logic          i_rst_n     = 1'b0;
    logic          i_in_valid  = 1'b0;
    logic          i_out_ready = 1'b0;
    apq_pkg::t_req i_in_data   = '0;
    logic          o_in_ready;
    logic          o_out_valid;
    apq_pkg::t_rsp o_out_data;

    addressable_priority_queue uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    t_queued_req   req_backlog[$];
    apq_pkg::t_rsp pending_tops[$];

    bit          rst_done  = 1'b0;
    int unsigned cycle_cnt = 0;
    int unsigned req_count = 0;
    int unsigned rsp_count = 0;
    int unsigned err_cnt   = 0;
    int unsigned hold_left = 0;
    bit          hold_done = 1'b0;

    // table model
    bit                              tbl_valid [apq_pkg::NUM_SLOTS];
    logic [apq_pkg::WEIGHT_BITS-1:0] tbl_weight [apq_pkg::NUM_SLOTS];
    logic [apq_pkg::ARR_BITS-1:0]    tbl_stamp [apq_pkg::NUM_SLOTS];
    logic [apq_pkg::ARR_BITS-1:0]    stamp_ctr = '0;

    // occupancy as seen by the stimulus generator
    bit plan_occ [apq_pkg::NUM_SLOTS];

    int unsigned n_ins = 0, n_raise = 0, n_rem = 0, n_query = 0;
    int unsigned n_occ_flag = 0, n_empty_flag = 0, n_sat = 0, peak_fill = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Apply one request to the model table and return the status plus new top.
    function automatic apq_pkg::t_rsp update_and_find_top(apq_pkg::t_req r);
        apq_pkg::t_rsp                   res;
        logic [apq_pkg::WEIGHT_BITS:0]   sum;
        logic [apq_pkg::WEIGHT_BITS-1:0] best_w;
        logic [apq_pkg::ARR_BITS-1:0]    best_a;
        int                              best_i;
        int                              fill;
        bit                              found;
        res        = '0;
        res.status = apq_pkg::STAT_OK;
        case (r.req_type)
            apq_pkg::REQ_INSERT: begin
                n_ins++;
                if (tbl_valid[r.entry_id]) begin
                    res.status = apq_pkg::STAT_OCCUPIED;
                end else begin
                    tbl_valid[r.entry_id]  = 1'b1;
                    tbl_weight[r.entry_id] = r.weight_value;
                    tbl_stamp[r.entry_id]  = stamp_ctr;
                    stamp_ctr              = stamp_ctr + apq_pkg::ARR_BITS'(1);
                end
            end
            apq_pkg::REQ_RAISE: begin
                n_raise++;
                if (!tbl_valid[r.entry_id]) begin
                    res.status = apq_pkg::STAT_EMPTY;
                end else begin
                    sum = {1'b0, tbl_weight[r.entry_id]} + {1'b0, r.weight_value};
                    if (sum > {1'b0, apq_pkg::WEIGHT_MAX}) begin
                        tbl_weight[r.entry_id] = apq_pkg::WEIGHT_MAX;
                        n_sat++;
                    end else begin
                        tbl_weight[r.entry_id] = sum[apq_pkg::WEIGHT_BITS-1:0];
                    end
                end
            end
            apq_pkg::REQ_REMOVE: begin
                n_rem++;
                if (!tbl_valid[r.entry_id])
                    res.status = apq_pkg::STAT_EMPTY;
                else
                    tbl_valid[r.entry_id] = 1'b0;
            end
            default: n_query++;
        endcase
        if (res.status == apq_pkg::STAT_OCCUPIED) n_occ_flag++;
        if (res.status == apq_pkg::STAT_EMPTY) n_empty_flag++;

        // heaviest wins, earliest stamp breaks ties, lowest slot breaks full ties
        found  = 1'b0;
        best_w = '0;
        best_a = '0;
        best_i = 0;
        fill   = 0;
        for (int i = 0; i < apq_pkg::NUM_SLOTS; i++) begin
            if (tbl_valid[i]) begin
                fill++;
                if (!found || tbl_weight[i] > best_w ||
                    (tbl_weight[i] == best_w && tbl_stamp[i] < best_a)) begin
                    found  = 1'b1;
                    best_w = tbl_weight[i];
                    best_a = tbl_stamp[i];
                    best_i = i;
                end
            end
        end
        if (fill > peak_fill) peak_fill = fill;
        res.top_valid  = found;
        res.top_id     = found ? best_i[apq_pkg::ID_BITS-1:0] : '0;
        res.top_weight = found ? best_w : '0;
        return res;
    endfunction

    function automatic void queue_req(logic [1:0] kind, int id, int weight, int gap, bit drain);
        t_queued_req q;
        q.req.req_type     = kind;
        q.req.entry_id     = id[apq_pkg::ID_BITS-1:0];
        q.req.weight_value = weight[apq_pkg::WEIGHT_BITS-1:0];
        q.gap              = gap;
        q.wait_drain       = drain;
        if (kind == apq_pkg::REQ_INSERT)
            plan_occ[id] = 1'b1;
        else if (kind == apq_pkg::REQ_REMOVE)
            plan_occ[id] = 1'b0;
        req_backlog.push_back(q);
    endfunction

    // random slot below pool that is (or is not) occupied, -1 if there is none
    function automatic int pick_slot(bit want_occ, int pool);
        int cand[$];
        for (int i = 0; i < pool; i++)
            if (plan_occ[i] == want_occ) cand.push_back(i);
        if (cand.size() == 0) return -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    function automatic int pick_weight();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) return $urandom_range(0, 65535);
        if (roll < 70) return $urandom_range(0, 3);          // ties
        if (roll < 85) return $urandom_range(65500, 65535);  // saturation
        return 1 << $urandom_range(0, apq_pkg::WEIGHT_BITS - 1);
    endfunction

    task automatic gen_random();
        int         phase, pool, roll, ins_pct, rem_pct, id, gap;
        bit         drain;
        logic [1:0] kind;
        for (int k = 0; k < RANDOM_REQS; k++) begin
            phase = (k / 200) % 4;   // fill, mixed, drain, small id pool
            pool  = (phase == 3) ? 8 : apq_pkg::NUM_SLOTS;
            roll  = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < 12) begin
                // noise: anything on any slot of the pool
                kind = 2'($urandom_range(0, 3));
                id   = $urandom_range(0, pool - 1);
            end else begin
                ins_pct = (phase == 0) ? 55 : (phase == 2) ? 15 : 35;
                rem_pct = (phase == 0) ? 10 : (phase == 2) ? 45 : 25;
                if (roll < ins_pct)
                    kind = apq_pkg::REQ_INSERT;
                else if (roll < ins_pct + rem_pct)
                    kind = apq_pkg::REQ_REMOVE;
                else if (roll < 90)
                    kind = apq_pkg::REQ_RAISE;
                else
                    kind = apq_pkg::REQ_QUERY;
                id = 0;
                if (kind == apq_pkg::REQ_INSERT) begin
                    id = pick_slot(1'b0, pool);
                    if (id < 0) kind = apq_pkg::REQ_RAISE;
                end
                if (kind == apq_pkg::REQ_RAISE || kind == apq_pkg::REQ_REMOVE) begin
                    id = pick_slot(1'b1, pool);
                    if (id < 0) begin
                        kind = apq_pkg::REQ_INSERT;
                        id   = pick_slot(1'b0, pool);
                    end
                end
                if (kind == apq_pkg::REQ_QUERY) id = $urandom_range(0, apq_pkg::NUM_SLOTS - 1);
            end
            gap   = $urandom_range(0, 7);
            drain = ($urandom_range(0, 99) < 30);
            if ((k / 160) % 5 == 4) begin
                gap   = 0;
                drain = 1'b0;
            end
            // keep offering beats while the output is held off
            if (k >= 360 && k < 470) drain = 1'b0;
            if (k == 700) drain = 1'b1;
            queue_req(kind, id, pick_weight(), gap, drain);
        end
    endtask

    // ---------------- driver ----------------
    t_queued_req cur_item;
    bit          have_item = 1'b0;
    int unsigned gap_left  = 0;
    int unsigned req_seen  = 0;

    always @(negedge i_clk) begin
        logic          nxt_valid;
        apq_pkg::t_req nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_in_data;
        if (rst_done) begin
            if (i_in_valid && req_count != req_seen) begin
                req_seen  = req_count;
                nxt_valid = 1'b0;
                have_item = 1'b0;
            end
            if (!nxt_valid) begin
                if (!have_item && req_backlog.size() != 0) begin
                    cur_item  = req_backlog.pop_front();
                    have_item = 1'b1;
                    gap_left  = cur_item.gap;
                end
                if (have_item && !(cur_item.wait_drain && pending_tops.size() != 0)) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end else begin
                        nxt_valid = 1'b1;
                        nxt_data  = cur_item.req;
                    end
                end
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data  <= nxt_data;
    end

    // ---------------- receiver ----------------
    int unsigned out_wait = 0;
    int unsigned rsp_seen = 0;

    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && req_count >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    always @(negedge i_clk) begin
        logic nxt_ready;
        bit   quiet;
        quiet = ((rsp_count / 128) % 4) == 3;
        if (rsp_seen != rsp_count) begin
            rsp_seen = rsp_count;
            out_wait = quiet ? 0 : $urandom_range(0, 7);
        end
        if (!rst_done || hold_left != 0) begin
            nxt_ready = 1'b0;
        end else if (out_wait != 0) begin
            nxt_ready = 1'b0;
            if (o_out_valid) out_wait--;   // stall counts only against a waiting beat
        end else begin
            nxt_ready = 1'b1;
        end
        i_out_ready <= nxt_ready;
    end

    // ---------------- monitor / checker ----------------
    always @(posedge i_clk) begin
        apq_pkg::t_rsp want;
        cycle_cnt++;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                pending_tops.push_back(update_and_find_top(i_in_data));
                req_count++;
            end
            if (o_out_valid && i_out_ready) begin
                rsp_count++;
                if (pending_tops.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: result beat with nothing outstanding: st=%0d v=%0d id=%0d w=%h",
                                 $time, o_out_data.status, o_out_data.top_valid,
                                 o_out_data.top_id, o_out_data.top_weight);
                end else begin
                    want = pending_tops.pop_front();
                    if (o_out_data !== want) begin
                        err_cnt++;
                        if (err_cnt <= 10)
                            $display("%0t: result %0d mismatch: got st=%0d v=%0d id=%0d w=%h %s",
                                     $time, rsp_count, o_out_data.status,
                                     o_out_data.top_valid, o_out_data.top_id,
                                     o_out_data.top_weight,
                                     $sformatf("want st=%0d v=%0d id=%0d w=%h",
                                               want.status, want.top_valid,
                                               want.top_id, want.top_weight));
                    end
                end
            end
        end
        if (cycle_cnt >= MAX_CYCLES) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
                     pending_tops.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------- stimulus and end of run ----------------
    initial begin
        // directed: empty table, flags, ties, saturation, bit patterns
        queue_req(apq_pkg::REQ_QUERY,  0,  16'h0000, 0, 1'b0);
        queue_req(apq_pkg::REQ_RAISE,  5,  16'h0064, 1, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 0,  16'h0000, 0, 1'b0);
        queue_req(apq_pkg::REQ_INSERT, 0,  16'h0000, 2, 1'b0);
        // tie on weight, older slot 0 stays top
        queue_req(apq_pkg::REQ_INSERT, 63, 16'h0000, 0, 1'b0);
        // occupied, stamp must not advance
        queue_req(apq_pkg::REQ_INSERT, 0,  16'h1234, 0, 1'b0);
        queue_req(apq_pkg::REQ_INSERT, 32, 16'hFFFF, 3, 1'b0);
        queue_req(apq_pkg::REQ_RAISE,  32, 16'h0001, 0, 1'b0);
        queue_req(apq_pkg::REQ_INSERT, 10, 16'hFFFE, 0, 1'b0);
        queue_req(apq_pkg::REQ_RAISE,  10, 16'hFFFF, 1, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 32, 16'h0000, 0, 1'b0);
        // reaches the maximum without saturating, earlier stamp beats slot 10
        queue_req(apq_pkg::REQ_RAISE,  63, 16'hFFFF, 0, 1'b0);
        queue_req(apq_pkg::REQ_RAISE,  0,  16'h0000, 0, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 63, 16'h0000, 4, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 10, 16'h0000, 0, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 0,  16'h0000, 0, 1'b0);
        queue_req(apq_pkg::REQ_RAISE,  10, 16'h0007, 0, 1'b0);
        queue_req(apq_pkg::REQ_INSERT, 21, 16'h5555, 0, 1'b0);
        queue_req(apq_pkg::REQ_INSERT, 42, 16'hAAAA, 5, 1'b0);
        queue_req(apq_pkg::REQ_RAISE,  21, 16'h8000, 0, 1'b0);
        queue_req(apq_pkg::REQ_QUERY,  63, 16'hFFFF, 0, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 21, 16'h0000, 0, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 42, 16'h0000, 7, 1'b0);
        queue_req(apq_pkg::REQ_REMOVE, 42, 16'h0000, 0, 1'b0);
        gen_random();

        repeat (10) @(negedge i_clk);
        i_rst_n  <= 1'b1;
        rst_done <= 1'b1;

        while (req_backlog.size() != 0 || have_item) @(posedge i_clk);
        while (pending_tops.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d insert, %0d raise, %0d remove, %0d query) in %0d cycles.",
                 req_count, n_ins, n_raise, n_rem, n_query, cycle_cnt);
        $display("Flags %0d occupied / %0d empty, %0d saturated raises, peak fill %0d, %0d errors.",
                 n_occ_flag, n_empty_flag, n_sat, peak_fill, err_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
